FILE: rtl/core/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants and types for the dictionary substring substitution coder.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int DEF_MAX_ENTRIES   = 32;
    localparam int DEF_MAX_ENTRY_LEN = 16;
    localparam int DEF_MAX_WORD      = 32;

    localparam int CFG_W = 6;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_EOW  = 2'd2;

    localparam logic [1:0] OUT_LIT  = 2'd0;
    localparam logic [1:0] OUT_CODE = 2'd1;
    localparam logic [1:0] OUT_SEP  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [3:0]  cpos;
        logic [7:0]  chr;
        logic [15:0] code;
        logic        eend;
    } t_cmd;

endpackage

FILE: rtl/core/dss_if.sv
// ----------------------------------------------------------------------------
// dss_in_if / dss_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  entry_index;
    logic [3:0]  char_pos;
    logic [7:0]  char_value;
    logic [15:0] entry_code;
    logic        entry_end;

    modport source (output valid, kind, entry_index, char_pos, char_value, entry_code,
                    entry_end, input ready);
    modport sink   (input valid, kind, entry_index, char_pos, char_value, entry_code,
                    entry_end, output ready);
endinterface

interface dss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_char;
    logic [15:0] out_code;
    logic        last;
    logic        truncated;

    modport source (output valid, out_kind, out_char, out_code, last, truncated,
                    input ready);
    modport sink   (input valid, out_kind, out_char, out_code, last, truncated,
                    output ready);
endinterface

FILE: rtl/core/dictionary_substring_substitution_top.sv
// ----------------------------------------------------------------------------
// dictionary_substring_substitution_top
// Greedy dictionary substitution coder: load entries, buffer a word, emit
// literals and code tokens in table-order first-match order, then a separator.
//
//   channel   dir   handshake          payload
//   i_in      in    valid / ready      kind, entry_index, char_pos, char_value,
//                                      entry_code, entry_end
//   o_out     out   valid / ready      out_kind, out_char, out_code, last,
//                                      truncated
//   cfg       in    i_cfg_we           i_cfg_wdata (entries_in_use)
//
// Load and text beats retire while the back end stays in S_IDLE; a two-entry
// queue lets the front take beats while the back end scans.
// End of word: per position, S_POS starts; each entry tried passes S_ENT and
// S_LEN, each character compared S_RD and S_CMP; then S_CODE emits a code
// token, or S_LIT emits a literal after the entry list runs out; S_SEP emits
// the separator once every position is consumed.
// Reset is synchronous; dictionary lengths read as zero until written.
// A stalled output holds the back end; the queue then fills and drops ready.
// ----------------------------------------------------------------------------
module dictionary_substring_substitution_top #(
    parameter int MAX_ENTRIES   = dss_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_ENTRY_LEN = dss_pkg::DEF_MAX_ENTRY_LEN,
    parameter int MAX_WORD      = dss_pkg::DEF_MAX_WORD
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dss_pkg::CFG_W-1:0] i_cfg_wdata,
    dss_in_if.sink                    i_in,
    dss_out_if.source                 o_out
);
    import dss_pkg::*;

    logic [CFG_W-1:0] r_entries;
    logic             q_full;
    logic             push;
    t_cmd             push_cmd;
    logic             pop;
    logic             q_valid;
    t_cmd             q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_we) begin
            r_entries <= i_cfg_wdata;
        end
    end

    dss_front #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    dss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    dss_back #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_ENTRY_LEN (MAX_ENTRY_LEN),
        .MAX_WORD      (MAX_WORD)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entries (r_entries),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );
endmodule

FILE: rtl/core/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Accept input beats, drop unknown kinds and out-of-range loads, build commands.
// ----------------------------------------------------------------------------
module dss_front #(
    parameter int MAX_ENTRIES   = dss_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_ENTRY_LEN = dss_pkg::DEF_MAX_ENTRY_LEN
) (
    dss_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output dss_pkg::t_cmd o_cmd
);
    import dss_pkg::*;

    logic keep;

    always_comb begin
        case (i_in.kind)
            KIND_LOAD: keep = (32'(i_in.entry_index) < MAX_ENTRIES) &&
                              (32'(i_in.char_pos) < MAX_ENTRY_LEN);
            KIND_TEXT: keep = 1'b1;
            KIND_EOW:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full && keep;

    assign o_cmd.op   = i_in.kind;
    assign o_cmd.idx  = i_in.entry_index;
    assign o_cmd.cpos = i_in.char_pos;
    assign o_cmd.chr  = i_in.char_value;
    assign o_cmd.code = i_in.entry_code;
    assign o_cmd.eend = i_in.entry_end;
endmodule

FILE: rtl/core/dss_fifo.sv
// ----------------------------------------------------------------------------
// dss_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module dss_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dss_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dss_pkg::t_cmd o_cmd
);
    import dss_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end
endmodule

FILE: rtl/core/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Execute commands: store dictionary and word, scan the word, emit results.
// ----------------------------------------------------------------------------
module dss_back #(
    parameter int MAX_ENTRIES   = dss_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_ENTRY_LEN = dss_pkg::DEF_MAX_ENTRY_LEN,
    parameter int MAX_WORD      = dss_pkg::DEF_MAX_WORD
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dss_pkg::CFG_W-1:0]  i_entries,
    input  logic                       i_q_valid,
    input  dss_pkg::t_cmd              i_q_cmd,
    output logic                       o_q_pop,
    dss_out_if.source                  o_out
);
    import dss_pkg::*;

    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = (MAX_ENTRY_LEN > 1) ? $clog2(MAX_ENTRY_LEN) : 1;
    localparam int LW  = $clog2(MAX_ENTRY_LEN + 1);
    localparam int DD  = MAX_ENTRIES * MAX_ENTRY_LEN;
    localparam int DAW = (DD > 1) ? $clog2(DD) : 1;
    localparam int WAW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int WCW = $clog2(MAX_WORD + 1);
    localparam int SW  = WCW + LW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POS  = 4'd1;
    localparam logic [3:0] S_ENT  = 4'd2;
    localparam logic [3:0] S_LEN  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_CODE = 4'd6;
    localparam logic [3:0] S_LIT  = 4'd7;
    localparam logic [3:0] S_SEP  = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [WCW-1:0]   r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [WCW-1:0]   r_pos, n_pos;
    logic [NW-1:0]    r_e, n_e;
    logic [IW-1:0]    r_i, n_i;
    logic [LW-1:0]    r_len, n_len;
    logic             r_lv_q;
    logic [MAX_ENTRIES-1:0] r_lvalid;

    logic             r_ov;
    logic [1:0]       r_okind;
    logic [7:0]       r_ochar;
    logic [15:0]      r_ocode;
    logic             r_olast;
    logic             r_otrunc;

    logic [NW-1:0]    n_lim;
    logic             can_emit;
    logic             emit;
    logic [1:0]       e_kind;
    logic [7:0]       e_char;
    logic [15:0]      e_code;
    logic             e_last;

    logic [EW-1:0]    ld_idx;
    logic [EW-1:0]    e_idx;
    logic             ld_we;
    logic             tx_we;
    logic             len_we;
    logic             len_re;
    logic             dc_re;
    logic             wb_re;
    logic             cd_re;
    logic [DAW-1:0]   dc_waddr;
    logic [DAW-1:0]   dc_raddr;
    logic [WAW-1:0]   wb_raddr;
    logic [7:0]       dc_rdata;
    logic [7:0]       wb_rdata;
    logic [15:0]      cd_rdata;
    logic [LW-1:0]    len_rdata;
    logic [LW-1:0]    len_now;
    logic [SW-1:0]    fit_end;

    assign n_lim    = (32'(i_entries) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(i_entries);
    assign can_emit = !r_ov || o_out.ready;
    assign ld_idx   = EW'(i_q_cmd.idx);
    assign e_idx    = EW'(r_e);
    assign o_q_pop  = (r_state == S_IDLE);

    assign ld_we    = (r_state == S_IDLE) && i_q_valid && (i_q_cmd.op == KIND_LOAD);
    assign tx_we    = (r_state == S_IDLE) && i_q_valid && (i_q_cmd.op == KIND_TEXT) &&
                      (32'(r_count) < MAX_WORD);
    assign len_we   = ld_we && i_q_cmd.eend;
    assign len_re   = (r_state == S_ENT) && (r_e != n_lim);
    assign dc_re    = (r_state == S_RD);
    assign wb_re    = (r_state == S_RD) || ((r_state == S_ENT) && (r_e == n_lim));
    assign cd_re    = (r_state == S_CMP) && (dc_rdata == wb_rdata) &&
                      ((LW'(r_i) + LW'(1)) == r_len);

    assign dc_waddr = DAW'(ld_idx) * DAW'(MAX_ENTRY_LEN) + DAW'(i_q_cmd.cpos);
    assign dc_raddr = DAW'(e_idx) * DAW'(MAX_ENTRY_LEN) + DAW'(r_i);
    assign wb_raddr = (r_state == S_RD) ? WAW'(r_pos + WCW'(r_i)) : WAW'(r_pos);
    assign len_now  = r_lv_q ? len_rdata : '0;
    assign fit_end  = SW'(r_pos) + SW'(len_now);

    dss_ram #(.WIDTH(8), .DEPTH(DD)) u_dict_chars (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (dc_waddr),
        .i_wdata (i_q_cmd.chr),
        .i_re    (dc_re),
        .i_raddr (dc_raddr),
        .o_rdata (dc_rdata)
    );

    dss_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_dict_codes (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_idx),
        .i_wdata (i_q_cmd.code),
        .i_re    (cd_re),
        .i_raddr (e_idx),
        .o_rdata (cd_rdata)
    );

    dss_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_dict_lens (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (ld_idx),
        .i_wdata (LW'(i_q_cmd.cpos) + LW'(1)),
        .i_re    (len_re),
        .i_raddr (e_idx),
        .o_rdata (len_rdata)
    );

    dss_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_word (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (WAW'(r_count)),
        .i_wdata (i_q_cmd.chr),
        .i_re    (wb_re),
        .i_raddr (wb_raddr),
        .o_rdata (wb_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_pos   = r_pos;
        n_e     = r_e;
        n_i     = r_i;
        n_len   = r_len;
        emit    = 1'b0;
        e_kind  = OUT_LIT;
        e_char  = '0;
        e_code  = '0;
        e_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        KIND_TEXT: begin
                            if (32'(r_count) < MAX_WORD) begin
                                n_count = r_count + WCW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        KIND_EOW: begin
                            n_pos   = '0;
                            n_state = S_POS;
                        end
                        default: ;
                    endcase
                end
            end
            S_POS: begin
                n_e = '0;
                n_state = (r_pos == r_count) ? S_SEP : S_ENT;
            end
            S_ENT: begin
                n_state = (r_e == n_lim) ? S_LIT : S_LEN;
            end
            S_LEN: begin
                n_len = len_now;
                n_i   = '0;
                if ((len_now != '0) && (fit_end <= SW'(r_count))) begin
                    n_state = S_RD;
                end else begin
                    n_e     = r_e + NW'(1);
                    n_state = S_ENT;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (dc_rdata != wb_rdata) begin
                    n_e     = r_e + NW'(1);
                    n_state = S_ENT;
                end else if ((LW'(r_i) + LW'(1)) == r_len) begin
                    n_state = S_CODE;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_RD;
                end
            end
            S_CODE: begin
                e_kind = OUT_CODE;
                e_code = cd_rdata;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_pos   = WCW'(SW'(r_pos) + SW'(r_len));
                    n_state = S_POS;
                end
            end
            S_LIT: begin
                e_kind = OUT_LIT;
                e_char = wb_rdata;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_pos   = r_pos + WCW'(1);
                    n_state = S_POS;
                end
            end
            S_SEP: begin
                e_kind = OUT_SEP;
                e_last = 1'b1;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_lvalid <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (len_we) begin
                r_lvalid[ld_idx] <= 1'b1;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_e   <= n_e;
        r_i   <= n_i;
        r_len <= n_len;
        if (len_re) begin
            r_lv_q <= r_lvalid[e_idx];
        end
        if (emit) begin
            r_okind  <= e_kind;
            r_ochar  <= e_char;
            r_ocode  <= e_code;
            r_olast  <= e_last;
            r_otrunc <= r_ovf;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_kind  = r_okind;
    assign o_out.out_char  = r_ochar;
    assign o_out.out_code  = r_ocode;
    assign o_out.last      = r_olast;
    assign o_out.truncated = r_otrunc;
endmodule
